[rtl/core/ucl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ucl_pkg;

  localparam int MAX_LINE     = 64;
  localparam int NUM_KEYWORDS = 58;
  localparam int KW_MAX_LEN   = 16;

  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 6;
  localparam int COUNT_W = 6;
  localparam int POS_W   = 6;
  localparam int CODE_W  = 5;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 2;

  // Longest line the count can describe, before line_limit is applied.
  localparam int LIMIT_CAP = MAX_LINE - 1;

  localparam logic [ADDR_W-1:0] ADDR_LINE_LIMIT = 2'd0;
  localparam logic [LIMIT_W-1:0] LINE_LIMIT_RESET = 6'd63;

  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_LOW_Z = 8'h7A;
  localparam logic [BYTE_W-1:0] CASE_SHIFT = 8'h20;

  localparam logic REPORT_COMMAND  = 1'b0;
  localparam logic REPORT_TOO_LONG = 1'b1;

  localparam logic [CODE_W-1:0] CMD_UNKNOWN = 5'd0;

  // Keywords are held right-justified: the last character sits in the low byte.
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KEYWORDS] = '{
    "HELP", "BANGZHU",
    "STATUS", "ZHUANGTAI",
    "GET MOTION", "ZITAI",
    "SAVE NOW", "BAOCUN",
    "HISTORY STATUS", "JILU ZHUANGTAI", "JILUZHUANGTAI",
    "GET HISTORY", "DAOCHU JILU", "DAOCHUJILU",
    "CLEAR HISTORY", "QINGKONG JILU", "QINGKONGJILU",
    "LED OFF", "GUANDENG",
    "LED ON", "KAIDENG",
    "LED BLINK", "SHANDENG",
    "BEEP ON", "FENGMING ON",
    "BEEP OFF", "FENGMING OFF",
    "BEEP TOGGLE", "JINGYIN",
    "BUZZER", "FENGMING",
    "ICON SMILE", "TUBIAO XIAOLIAN", "TUBIAOXIAOLIAN",
    "ICON TEMP", "TUBIAO WENDU", "TUBIAOWENDU",
    "ICON LIGHT", "TUBIAO GUANGZHAO", "TUBIAOGUANGZHAO",
    "ICON LED", "TUBIAO DENG", "TUBIAODENG",
    "ICON BUZZER", "TUBIAO FENGMING", "TUBIAOFENGMING",
    "ICON BT", "TUBIAO LANYA", "TUBIAOLANYA",
    "ICON ERROR", "TUBIAO CUOWU", "TUBIAOCUOWU",
    "ICON MOTION", "TUBIAO ZITAI", "TUBIAOZITAI",
    "ICON HISTORY", "TUBIAO JILU", "TUBIAOJILU"
  };

  localparam logic [CODE_W-1:0] KW_CODE [NUM_KEYWORDS] = '{
    5'd1, 5'd1,
    5'd2, 5'd2,
    5'd3, 5'd3,
    5'd4, 5'd4,
    5'd5, 5'd5, 5'd5,
    5'd6, 5'd6, 5'd6,
    5'd7, 5'd7, 5'd7,
    5'd8, 5'd8,
    5'd9, 5'd9,
    5'd10, 5'd10,
    5'd11, 5'd11,
    5'd12, 5'd12,
    5'd13, 5'd13,
    5'd14, 5'd14,
    5'd15, 5'd15, 5'd15,
    5'd16, 5'd16, 5'd16,
    5'd17, 5'd17, 5'd17,
    5'd18, 5'd18, 5'd18,
    5'd19, 5'd19, 5'd19,
    5'd20, 5'd20, 5'd20,
    5'd21, 5'd21, 5'd21,
    5'd22, 5'd22, 5'd22,
    5'd23, 5'd23, 5'd23
  };

  function automatic int kw_len(int k);
    int n;
    n = 0;
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      if (KW_TEXT[k][8*i +: 8] != CHAR_NUL) n++;
    end
    return n;
  endfunction

  // Character of keyword k at position pos, NUL past its end.
  function automatic logic [BYTE_W-1:0] kw_char(int k, logic [POS_W-1:0] pos);
    int len;
    len = kw_len(k);
    if (int'(pos) >= len) return CHAR_NUL;
    return KW_TEXT[k][8*(len - 1 - int'(pos)) +: 8];
  endfunction

endpackage

`default_nettype wire

[rtl/core/ucl_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Received byte channel.
interface ucl_rx_if import ucl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              rx_error;

  modport source (output valid, output rx_byte, output rx_error, input ready);
  modport sink   (input valid, input rx_byte, input rx_error, output ready);
endinterface

// Report channel.
interface ucl_report_if import ucl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              report_kind;
  logic [CODE_W-1:0] command_code;

  modport source (output valid, output report_kind, output command_code, input ready);
  modport sink   (input valid, input report_kind, input command_code, output ready);
endinterface

`default_nettype wire

[rtl/core/uart_command_line_recognizer_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// A report enters the output register in the cycle after the word that ends or overflows its line is taken.
// One word per cycle while no report waits on report.ready; the keyword compare and line state update sit in a
//   single level of logic between the line state registers and the output register.
// Reset (synchronous, rst high): line state cleared, all keywords alive, output empty,
//   line_limit back to 63. No clearing pass; the block takes words straight away.

module uart_command_line_recognizer_core import ucl_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  ucl_rx_if.sink                  rx,
  ucl_report_if.source            report,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  // Configuration register
  logic [LIMIT_W-1:0] line_limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LINE_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_LINE_LIMIT) begin
      line_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_LINE_LIMIT) prdata = DATA_W'(line_limit);
  end

  // Effective limit: the smaller of line_limit and what one line may ever hold.
  logic [LIMIT_W-1:0] limit;
  assign limit = (int'(line_limit) > LIMIT_CAP) ? LIMIT_W'(LIMIT_CAP) : line_limit;

  // Line state
  logic [COUNT_W-1:0]      raw_count, raw_count_next;
  logic                    overflowed, overflowed_next;
  logic                    nul_seen, nul_seen_next;
  logic                    text_started, text_started_next;
  logic                    space_pending, space_pending_next;
  logic [POS_W-1:0]        norm_pos, norm_pos_next;
  logic [NUM_KEYWORDS-1:0] match_alive, match_alive_next;

  // Output register
  logic              out_valid;
  logic              out_kind;
  logic [CODE_W-1:0] out_code;

  logic rx_fire;
  assign rx.ready = !out_valid || report.ready;
  assign rx_fire  = rx.valid && rx.ready;

  assign report.valid        = out_valid;
  assign report.report_kind  = out_kind;
  assign report.command_code = out_code;

  // Byte classification
  logic              is_term, is_blank, is_nul;
  logic [BYTE_W-1:0] ch_upper;

  assign is_term  = (rx.rx_byte == CHAR_CR) || (rx.rx_byte == CHAR_LF);
  assign is_blank = (rx.rx_byte == CHAR_SPACE) || (rx.rx_byte == CHAR_TAB);
  assign is_nul   = (rx.rx_byte == CHAR_NUL);
  assign ch_upper = (rx.rx_byte >= CHAR_LOW_A && rx.rx_byte <= CHAR_LOW_Z)
                  ? rx.rx_byte - CASE_SHIFT : rx.rx_byte;

  // Normalised position advances but holds at the top of its range.
  logic [POS_W-1:0] pos_after_space, pos_after_char;
  assign pos_after_space = !space_pending ? norm_pos
                         : (norm_pos == '1) ? norm_pos : norm_pos + 1'b1;
  assign pos_after_char  = (pos_after_space == '1) ? pos_after_space
                         : pos_after_space + 1'b1;

  // Keyword compare for a printable character, with the pending space ahead of it.
  logic [NUM_KEYWORDS-1:0] alive_appended;
  always_comb begin
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      alive_appended[k] = match_alive[k]
                        && (!space_pending || kw_char(k, norm_pos) == CHAR_SPACE)
                        && (kw_char(k, pos_after_space) == ch_upper);
    end
  end

  // Final code: a live keyword whose length equals the normalised text.
  // Keywords are distinct, so at most one hits and the codes can be ORed.
  logic [CODE_W-1:0] final_code;
  always_comb begin
    final_code = CMD_UNKNOWN;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (match_alive[k] && int'(norm_pos) == kw_len(k)) final_code = final_code | KW_CODE[k];
    end
  end

  // Per-word step
  logic              res_valid;
  logic              res_kind;
  logic [CODE_W-1:0] res_code;

  always_comb begin
    raw_count_next     = raw_count;
    overflowed_next    = overflowed;
    nul_seen_next      = nul_seen;
    text_started_next  = text_started;
    space_pending_next = space_pending;
    norm_pos_next      = norm_pos;
    match_alive_next   = match_alive;
    res_valid          = 1'b0;
    res_kind           = REPORT_COMMAND;
    res_code           = CMD_UNKNOWN;

    if (rx.rx_error || is_term) begin
      // Receive error drops the line silently; a terminator reports a non-empty one.
      if (!rx.rx_error && !overflowed && raw_count != '0) begin
        res_valid = 1'b1;
        res_code  = final_code;
      end
      raw_count_next     = '0;
      overflowed_next    = 1'b0;
      nul_seen_next      = 1'b0;
      text_started_next  = 1'b0;
      space_pending_next = 1'b0;
      norm_pos_next      = '0;
      match_alive_next   = '1;
    end else if (overflowed) begin
      // Drop bytes until the terminator.
    end else if (raw_count >= limit) begin
      raw_count_next     = '0;
      overflowed_next    = 1'b1;
      nul_seen_next      = 1'b0;
      text_started_next  = 1'b0;
      space_pending_next = 1'b0;
      norm_pos_next      = '0;
      match_alive_next   = '1;
      res_valid          = 1'b1;
      res_kind           = REPORT_TOO_LONG;
    end else begin
      raw_count_next = raw_count + 1'b1;
      if (!nul_seen) begin
        if (is_nul) begin
          nul_seen_next = 1'b1;
        end else if (is_blank) begin
          if (text_started) space_pending_next = 1'b1;
        end else begin
          match_alive_next   = alive_appended;
          norm_pos_next      = pos_after_char;
          space_pending_next = 1'b0;
          text_started_next  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count     <= '0;
      overflowed    <= 1'b0;
      nul_seen      <= 1'b0;
      text_started  <= 1'b0;
      space_pending <= 1'b0;
      norm_pos      <= '0;
      match_alive   <= '1;
      out_valid     <= 1'b0;
    end else begin
      if (rx_fire) begin
        raw_count     <= raw_count_next;
        overflowed    <= overflowed_next;
        nul_seen      <= nul_seen_next;
        text_started  <= text_started_next;
        space_pending <= space_pending_next;
        norm_pos      <= norm_pos_next;
        match_alive   <= match_alive_next;
        out_valid     <= res_valid;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the report word; the slot is free or being emptied whenever rx_fire is high.
  always_ff @(posedge clk) begin
    if (rx_fire && res_valid) begin
      out_kind <= res_kind;
      out_code <= res_code;
    end
  end

endmodule

`default_nettype wire
